FILE: src/triangle_face_normal_unit_defines.svh
// assertion macros for the triangle face normal unit
`ifndef TRIANGLE_FACE_NORMAL_UNIT_DEFINES_SVH
`define TRIANGLE_FACE_NORMAL_UNIT_DEFINES_SVH
`ifndef SYNTH
`define TFN_ASSERT(lbl, prop) lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
    else $error("assertion failed");
`define TFN_ASSERT_RST(lbl, prop) lbl: assert property (@(posedge i_clk) prop) \
    else $error("assertion failed");
`else
`define TFN_ASSERT(lbl, prop)
`define TFN_ASSERT_RST(lbl, prop)
`endif
`endif

FILE: src/tfn_pkg.sv
// shared types for the triangle face normal unit
package tfn_pkg;
    typedef struct packed {
        logic degenerate;
        logic mesh_end;
    } t_tri_flags;
endpackage

FILE: src/tfn_cross.sv
// edge vectors and cross product, three register stages
module tfn_cross #(
    parameter int CW = 16,
    parameter int NW = 2 * CW + 3
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_vld,
    input  logic                 i_mesh,
    input  logic signed [CW-1:0] i_ax, i_ay, i_az,
    input  logic signed [CW-1:0] i_bx, i_by, i_bz,
    input  logic signed [CW-1:0] i_cx, i_cy, i_cz,
    output logic                 o_vld,
    output logic                 o_mesh,
    output logic signed [NW-1:0] o_nx, o_ny, o_nz
);
    localparam int EW = CW + 1;
    localparam int PW = 2 * EW;

    logic [2:0] r_vld;
    logic [2:0] r_mesh;
    logic signed [EW-1:0] r_ux, r_uy, r_uz, r_vx, r_vy, r_vz;
    logic signed [PW-1:0] r_p0, r_p1, r_p2, r_p3, r_p4, r_p5;
    logic signed [NW-1:0] r_nx, r_ny, r_nz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[1:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        r_mesh <= {r_mesh[1:0], i_mesh};
        r_ux <= EW'(i_bx) - EW'(i_ax);
        r_uy <= EW'(i_by) - EW'(i_ay);
        r_uz <= EW'(i_bz) - EW'(i_az);
        r_vx <= EW'(i_cx) - EW'(i_ax);
        r_vy <= EW'(i_cy) - EW'(i_ay);
        r_vz <= EW'(i_cz) - EW'(i_az);
        r_p0 <= PW'(r_uy) * PW'(r_vz);
        r_p1 <= PW'(r_uz) * PW'(r_vy);
        r_p2 <= PW'(r_uz) * PW'(r_vx);
        r_p3 <= PW'(r_ux) * PW'(r_vz);
        r_p4 <= PW'(r_ux) * PW'(r_vy);
        r_p5 <= PW'(r_uy) * PW'(r_vx);
        r_nx <= NW'(r_p0) - NW'(r_p1);
        r_ny <= NW'(r_p2) - NW'(r_p3);
        r_nz <= NW'(r_p4) - NW'(r_p5);
    end

    assign o_vld  = r_vld[2];
    assign o_mesh = r_mesh[2];
    assign o_nx   = r_nx;
    assign o_ny   = r_ny;
    assign o_nz   = r_nz;
endmodule

FILE: src/tfn_sqsum.sv
// squared length and component magnitudes, two register stages
module tfn_sqsum #(
    parameter int NW = 35,
    parameter int SW = 2 * NW + 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_vld,
    input  logic                 i_mesh,
    input  logic signed [NW-1:0] i_nx, i_ny, i_nz,
    output logic                 o_vld,
    output tfn_pkg::t_tri_flags  o_flags,
    output logic [NW-1:0]        o_mx, o_my, o_mz,
    output logic [2:0]           o_sgn,
    output logic [SW-1:0]        o_sq
);
    localparam int QW = 2 * NW;

    logic [1:0]           r_vld;
    logic [1:0]           r_mesh;
    logic signed [QW-1:0] r_qx, r_qy, r_qz;
    logic [NW-1:0]        r_mx, r_my, r_mz, r_mx2, r_my2, r_mz2;
    logic [2:0]           r_sgn, r_sgn2;
    logic [SW-1:0]        r_sq;
    logic [SW-1:0]        n_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[0], i_vld};
        end
    end

    assign n_sq = SW'($unsigned(r_qx)) + SW'($unsigned(r_qy)) + SW'($unsigned(r_qz));

    always_ff @(posedge i_clk) begin
        r_mesh <= {r_mesh[0], i_mesh};
        r_qx <= QW'(i_nx) * QW'(i_nx);
        r_qy <= QW'(i_ny) * QW'(i_ny);
        r_qz <= QW'(i_nz) * QW'(i_nz);
        r_mx <= i_nx[NW-1] ? NW'(-i_nx) : NW'(i_nx);
        r_my <= i_ny[NW-1] ? NW'(-i_ny) : NW'(i_ny);
        r_mz <= i_nz[NW-1] ? NW'(-i_nz) : NW'(i_nz);
        r_sgn <= {i_nx[NW-1], i_ny[NW-1], i_nz[NW-1]};
        r_mx2 <= r_mx;
        r_my2 <= r_my;
        r_mz2 <= r_mz;
        r_sgn2 <= r_sgn;
        r_sq <= n_sq;
    end

    assign o_vld              = r_vld[1];
    assign o_flags.degenerate = (r_sq == '0);
    assign o_flags.mesh_end   = r_mesh[1];
    assign o_mx  = r_mx2;
    assign o_my  = r_my2;
    assign o_mz  = r_mz2;
    assign o_sgn = r_sgn2;
    assign o_sq  = r_sq;
endmodule

FILE: src/tfn_isqrt.sv
// pipelined floor square root, one root bit per stage
module tfn_isqrt #(
    parameter int SW  = 72,
    parameter int SBW = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_vld,
    input  logic [SW-1:0]       i_sq,
    input  logic [SBW-1:0]      i_sb,
    output logic                o_vld,
    output logic [SW/2-1:0]     o_root,
    output logic [SBW-1:0]      o_sb
);
    localparam int RW = SW / 2;

    logic            r_vld  [0:RW];
    logic [SW-1:0]   r_rem  [0:RW];
    logic [RW-1:0]   r_root [0:RW];
    logic [SBW-1:0]  r_sb   [0:RW];

    assign r_vld[0]  = i_vld;
    assign r_rem[0]  = i_sq;
    assign r_root[0] = '0;
    assign r_sb[0]   = i_sb;

    for (genvar g = 0; g < RW; g++) begin : g_stage
        localparam int B = RW - 1 - g;
        logic [SW-1:0] n_trial;
        logic          n_take;
        // (root + 2^b)^2 - root^2
        assign n_trial = (SW'(r_root[g]) << (B + 1)) | (SW'(1) << (2 * B));
        assign n_take  = (r_rem[g] >= n_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g+1] <= 1'b0;
            end else begin
                r_vld[g+1] <= r_vld[g];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[g+1]  <= n_take ? r_rem[g] - n_trial : r_rem[g];
            r_root[g+1] <= n_take ? (r_root[g] | (RW'(1) << B)) : r_root[g];
            r_sb[g+1]   <= r_sb[g];
        end
    end

    assign o_vld  = r_vld[RW];
    assign o_root = r_root[RW];
    assign o_sb   = r_sb[RW];
endmodule

FILE: src/tfn_div.sv
// pipelined restoring divider: magnitude * 2^F / root, one quotient bit per stage
module tfn_div #(
    parameter int RW  = 36,
    parameter int MW  = 35,
    parameter int F   = 14,
    parameter int SBW = 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_vld,
    input  logic [MW-1:0]   i_mag,
    input  logic [RW-1:0]   i_root,
    input  logic [SBW-1:0]  i_sb,
    output logic            o_vld,
    output logic [F+1:0]    o_q,
    output logic [SBW-1:0]  o_sb
);
    localparam int QW = F + 2;

    logic            r_vld  [0:QW];
    logic [RW:0]     r_rem  [0:QW];
    logic [RW-1:0]   r_root [0:QW];
    logic [1:0]      r_lo   [0:QW];
    logic [QW-1:0]   r_q    [0:QW];
    logic [SBW-1:0]  r_sb   [0:QW];

    // quotient stays below 2^(F+2), so only the low quotient bits are formed
    assign r_vld[0]  = i_vld;
    assign r_rem[0]  = (RW + 1)'(i_mag >> 2);
    assign r_root[0] = i_root;
    assign r_lo[0]   = i_mag[1:0];
    assign r_q[0]    = '0;
    assign r_sb[0]   = i_sb;

    for (genvar g = 0; g < QW; g++) begin : g_stage
        logic        n_bit;
        logic [RW:0] n_cand;
        logic        n_ge;
        assign n_bit  = (g == 0) ? r_lo[g][1] : ((g == 1) ? r_lo[g][0] : 1'b0);
        assign n_cand = {r_rem[g][RW-1:0], n_bit};
        assign n_ge   = (n_cand >= {1'b0, r_root[g]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g+1] <= 1'b0;
            end else begin
                r_vld[g+1] <= r_vld[g];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[g+1]  <= n_ge ? n_cand - {1'b0, r_root[g]} : n_cand;
            r_root[g+1] <= r_root[g];
            r_lo[g+1]   <= r_lo[g];
            r_q[g+1]    <= {r_q[g][QW-2:0], n_ge};
            r_sb[g+1]   <= r_sb[g];
        end
    end

    assign o_vld = r_vld[QW];
    assign o_q   = r_q[QW];
    assign o_sb  = r_sb[QW];
endmodule

FILE: src/triangle_face_normal_unit.sv
// pipeline from start to o_valid: cross product, squared sum, square root, dividers, output register
// throughput: one triangle per cycle; busy is always low
// the latency is set by the square root pipeline (one root bit per stage) and the dividers
// reset clears every valid bit in the pipeline; no result appears for items in flight
// o_valid marks each result for exactly one cycle
// top level of the triangle face normal unit
`include "triangle_face_normal_unit_defines.svh"
module triangle_face_normal_unit #(
    parameter int COORD_WIDTH      = 16,
    parameter int NORMAL_FRAC_BITS = 14
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic signed [COORD_WIDTH-1:0]   i_vertex_a_x, i_vertex_a_y, i_vertex_a_z,
    input  logic signed [COORD_WIDTH-1:0]   i_vertex_b_x, i_vertex_b_y, i_vertex_b_z,
    input  logic signed [COORD_WIDTH-1:0]   i_vertex_c_x, i_vertex_c_y, i_vertex_c_z,
    input  logic                            i_mesh_end_in,
    output logic                            o_valid,
    output logic signed [NORMAL_FRAC_BITS+1:0] o_normal_x, o_normal_y, o_normal_z,
    output logic                            o_degenerate,
    output logic                            o_mesh_end_out
);
    localparam int F   = NORMAL_FRAC_BITS;
    localparam int OW  = F + 2;
    localparam int NW  = 2 * COORD_WIDTH + 3;
    localparam int SW  = 2 * NW + 2;
    localparam int RW  = SW / 2;
    localparam int FLW = $bits(tfn_pkg::t_tri_flags);
    localparam int ISB = 3 * NW + 3 + FLW;
    localparam logic signed [OW-1:0] LIM = OW'(1) << F;

    logic                 c_vld, c_mesh;
    logic signed [NW-1:0] c_nx, c_ny, c_nz;
    logic                 s_vld;
    tfn_pkg::t_tri_flags  s_flags;
    logic [NW-1:0]        s_mx, s_my, s_mz;
    logic [2:0]           s_sgn;
    logic [SW-1:0]        s_sq;
    logic                 q_vld;
    logic [RW-1:0]        q_root;
    logic [ISB-1:0]       q_sb;
    logic [NW-1:0]        q_mx, q_my, q_mz;
    logic [2:0]           q_sgn;
    tfn_pkg::t_tri_flags  q_flags;
    logic                 d_vld;
    logic [OW-1:0]        d_qx, d_qy, d_qz;
    logic [FLW:0]         d_sbx;
    logic                 d_sy, d_sz;
    tfn_pkg::t_tri_flags  d_flags;
    logic                 r_valid;
    logic signed [OW-1:0] r_nx, r_ny, r_nz;
    logic                 r_deg, r_mesh;

    function automatic logic [OW-1:0] f_comp(input logic [OW-1:0] q, input logic neg,
                                             input logic deg);
        logic [OW-1:0] m;
        m = (q > OW'(LIM)) ? OW'(LIM) : q;
        if (deg) begin
            f_comp = '0;
        end else begin
            f_comp = neg ? OW'(-m) : m;
        end
    endfunction

    assign busy = 1'b0;

    tfn_cross #(.CW(COORD_WIDTH), .NW(NW)) u_cross (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(start), .i_mesh(i_mesh_end_in),
        .i_ax(i_vertex_a_x), .i_ay(i_vertex_a_y), .i_az(i_vertex_a_z),
        .i_bx(i_vertex_b_x), .i_by(i_vertex_b_y), .i_bz(i_vertex_b_z),
        .i_cx(i_vertex_c_x), .i_cy(i_vertex_c_y), .i_cz(i_vertex_c_z),
        .o_vld(c_vld), .o_mesh(c_mesh), .o_nx(c_nx), .o_ny(c_ny), .o_nz(c_nz)
    );

    tfn_sqsum #(.NW(NW), .SW(SW)) u_sqsum (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(c_vld), .i_mesh(c_mesh),
        .i_nx(c_nx), .i_ny(c_ny), .i_nz(c_nz),
        .o_vld(s_vld), .o_flags(s_flags), .o_mx(s_mx), .o_my(s_my), .o_mz(s_mz),
        .o_sgn(s_sgn), .o_sq(s_sq)
    );

    tfn_isqrt #(.SW(SW), .SBW(ISB)) u_isqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(s_vld), .i_sq(s_sq),
        .i_sb({s_mx, s_my, s_mz, s_sgn, s_flags}),
        .o_vld(q_vld), .o_root(q_root), .o_sb(q_sb)
    );

    assign {q_mx, q_my, q_mz, q_sgn, q_flags} = q_sb;

    tfn_div #(.RW(RW), .MW(NW), .F(F), .SBW(FLW + 1)) u_div_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(q_vld), .i_mag(q_mx), .i_root(q_root),
        .i_sb({q_sgn[2], q_flags}), .o_vld(d_vld), .o_q(d_qx), .o_sb(d_sbx)
    );

    // y and z lanes run in lockstep with x, so their valids are not needed
    tfn_div #(.RW(RW), .MW(NW), .F(F), .SBW(1)) u_div_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(q_vld), .i_mag(q_my), .i_root(q_root),
        .i_sb(q_sgn[1]), .o_vld(), .o_q(d_qy), .o_sb(d_sy)
    );

    tfn_div #(.RW(RW), .MW(NW), .F(F), .SBW(1)) u_div_z (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(q_vld), .i_mag(q_mz), .i_root(q_root),
        .i_sb(q_sgn[0]), .o_vld(), .o_q(d_qz), .o_sb(d_sz)
    );

    assign d_flags = d_sbx[FLW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_nx   <= f_comp(d_qx, d_sbx[FLW], d_flags.degenerate);
        r_ny   <= f_comp(d_qy, d_sy, d_flags.degenerate);
        r_nz   <= f_comp(d_qz, d_sz, d_flags.degenerate);
        r_deg  <= d_flags.degenerate;
        r_mesh <= d_flags.mesh_end;
    end

    assign o_valid        = r_valid;
    assign o_normal_x     = r_nx;
    assign o_normal_y     = r_ny;
    assign o_normal_z     = r_nz;
    assign o_degenerate   = r_deg;
    assign o_mesh_end_out = r_mesh;

    `TFN_ASSERT(a_deg_zero, o_valid && o_degenerate |-> o_normal_x == '0 && o_normal_y == '0 && o_normal_z == '0)
    `TFN_ASSERT(a_range_x, o_valid |-> o_normal_x <= LIM && o_normal_x >= -LIM)
    `TFN_ASSERT(a_range_z, o_valid |-> o_normal_z <= LIM && o_normal_z >= -LIM)
    `TFN_ASSERT_RST(a_rst_clr, !i_rst_n |=> !o_valid)
endmodule
